/* rtl/core/text_console_put_scroll_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the text console
// Immediate-cycle and next-cycle implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_PUT_SCROLL_TOP_ASSERT_SVH
`define TEXT_CONSOLE_PUT_SCROLL_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCPS_ASSERT_NOW(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCPS_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/core/cps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console package
// Operation codes, command kinds, the command word and fixed field widths.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int COL_FW    = 7;
    localparam int ROW_FW    = 7;
    localparam int OUT_ROW_W = 5;
    localparam int ADDR_FW   = 13;
    localparam int IN_ADDR_W = 11;
    localparam int CELL_W    = 16;
    localparam int CHAR_W    = 8;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [3:0]        BLANK_BG     = 4'h0;
    localparam logic [3:0]        BLANK_FG     = 4'hF;
    localparam logic [CELL_W-1:0] BLANK_CELL   = {BLANK_BG, BLANK_FG, SPACE_CODE};

    typedef enum logic [1:0] {
        OP_PUT_CHAR   = 2'd0,
        OP_SET_CURSOR = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_READ_CELL  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_PUT_CHAR,
        K_NEWLINE,
        K_SET_CURSOR,
        K_CLEAR,
        K_READ,
        K_READ_NONE
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [CELL_W-1:0]   word;
        logic [COL_FW-1:0]   col;
        logic [ROW_FW-1:0]   row;
        logic [ADDR_FW-1:0]  addr;
    } cmd_t;

endpackage

/* rtl/core/cps_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console front end
// Accepts input transfers, decodes them into commands and saturates operands.
// ----------------------------------------------------------------------------
module cps_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    enable,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              operation,
    input  logic [7:0]              char_code,
    input  logic [15:0]             attribute,
    input  logic [6:0]              new_column,
    input  logic [4:0]              new_row,
    input  logic [10:0]             cell_address,
    output logic                    cmd_valid,
    input  logic                    cmd_ready,
    output cps_pkg::cmd_t           cmd
);
    import cps_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    assign in_ready  = enable && (!valid_reg || cmd_ready);
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        cmd_next      = cmd_reg;
        cmd_next.word = attribute | {{(CELL_W - CHAR_W){1'b0}}, char_code};
        cmd_next.col  = (new_column > COL_FW'(COLUMNS - 1)) ? COL_FW'(COLUMNS - 1) : new_column;
        cmd_next.row  = (ROW_FW'(new_row) > ROW_FW'(ROWS)) ? ROW_FW'(ROWS) : ROW_FW'(new_row);
        cmd_next.addr = ADDR_FW'(cell_address);
        case (op_t'(operation))
            OP_PUT_CHAR:   cmd_next.kind = (char_code == NEWLINE_CODE) ? K_NEWLINE : K_PUT_CHAR;
            OP_SET_CURSOR: cmd_next.kind = K_SET_CURSOR;
            OP_CLEAR:      cmd_next.kind = K_CLEAR;
            OP_READ_CELL:
            begin
                cmd_next.kind = ((ADDR_FW + 1)'(cell_address) < (ADDR_FW + 1)'(CELLS)) ?
                                K_READ : K_READ_NONE;
            end
            default:       cmd_next.kind = K_READ_NONE;
        endcase

        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

/* rtl/core/cps_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console command queue
// Two-entry queue that decouples command decoding from execution.
// ----------------------------------------------------------------------------
module cps_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  cps_pkg::cmd_t wr_cmd,
    output logic          rd_valid,
    input  logic          rd_pop,
    output cps_pkg::cmd_t rd_cmd
);
    import cps_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    cmd_t            slots_reg [DEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   wptr_next;
    logic [PW-1:0]   rptr_reg;
    logic [PW-1:0]   rptr_next;
    logic [PW:0]     count_reg;
    logic [PW:0]     count_next;
    logic            push;
    logic            pop;

    assign wr_ready = (count_reg != (PW + 1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = slots_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + (PW + 1)'(push) - (PW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wptr_reg] <= wr_cmd;
        end
    end

endmodule

/* rtl/core/cps_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console execution engine
// Owns the screen memory and cursor, runs scroll and clear sweeps, and holds
// the result register.
// ----------------------------------------------------------------------------
module cps_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    output logic                              init_done,
    input  logic                              cmd_valid,
    output logic                              cmd_pop,
    input  cps_pkg::cmd_t                     cmd,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cps_pkg::COL_FW-1:0]        out_column,
    output logic [cps_pkg::OUT_ROW_W-1:0]     out_row,
    output logic [cps_pkg::CELL_W-1:0]        out_data
);
    import cps_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int AW    = $clog2(CELLS);

    localparam logic [CW-1:0] COL_LAST    = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_PENDING = RW'(ROWS);
    localparam logic [RW-1:0] ROW_LAST    = RW'(ROWS - 1);
    localparam logic [AW-1:0] CELL_LAST   = AW'(CELLS - 1);
    localparam logic [AW-1:0] MOVE_LAST   = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] ROW_STRIDE  = AW'(COLUMNS);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_ZERO,
        ST_PUT,
        ST_FILL,
        ST_READ
    } state_t;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    state_t              state_reg;
    state_t              state_next;
    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       ptr_next;
    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       col_next;
    logic [RW-1:0]       row_reg;
    logic [RW-1:0]       row_next;
    cmd_t                cur_reg;
    cmd_t                cur_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [COL_FW-1:0]   out_col_reg;
    logic [COL_FW-1:0]   out_col_next;
    logic [OUT_ROW_W-1:0] out_row_reg;
    logic [OUT_ROW_W-1:0] out_row_next;
    logic [CELL_W-1:0]   out_data_reg;
    logic [CELL_W-1:0]   out_data_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic                out_free;
    logic                emit;
    logic [CELL_W-1:0]   emit_data;
    logic                do_put;
    cmd_t                put_cmd;
    logic [AW-1:0]       cursor_idx;
    logic [ROW_FW-1:0]   row_wide;

    assign init_done  = (state_reg != ST_INIT);
    assign out_valid  = out_valid_reg;
    assign out_column = out_col_reg;
    assign out_row    = out_row_reg;
    assign out_data   = out_data_reg;
    assign out_free   = !out_valid_reg || out_ready;
    assign cursor_idx = AW'(AW'(row_reg) * ROW_STRIDE + AW'(col_reg));

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg;
        mem_wdata      = '0;
        mem_raddr      = ptr_reg + ROW_STRIDE;
        cmd_pop        = 1'b0;
        emit           = 1'b0;
        emit_data      = '0;
        do_put         = 1'b0;
        put_cmd        = (state_reg == ST_PUT) ? cur_reg : cmd;
        row_wide       = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = BLANK_CELL;
                ptr_next  = ptr_reg + 1'b1;
                if (ptr_reg == CELL_LAST)
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                mem_raddr = cmd.addr[AW-1:0];
                if (cmd_valid && out_free)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    case (cmd.kind)
                        K_SET_CURSOR:
                        begin
                            col_next = cmd.col[CW-1:0];
                            row_next = cmd.row[RW-1:0];
                            emit     = 1'b1;
                        end
                        K_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            ptr_next   = '0;
                            state_next = ST_FILL;
                        end
                        K_READ:
                        begin
                            state_next = ST_READ;
                        end
                        K_PUT_CHAR, K_NEWLINE:
                        begin
                            if (row_reg == ROW_PENDING)
                            begin
                                col_next   = '0;
                                row_next   = ROW_LAST;
                                ptr_next   = '0;
                                state_next = ST_SCROLL_RD;
                            end
                            else
                            begin
                                do_put = 1'b1;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCROLL_RD:
            begin
                state_next = ST_SCROLL_WR;
            end
            ST_SCROLL_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
                ptr_next  = ptr_reg + 1'b1;
                state_next = (ptr_reg == MOVE_LAST) ? ST_ZERO : ST_SCROLL_RD;
            end
            ST_ZERO:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                ptr_next  = ptr_reg + 1'b1;
                if (ptr_reg == CELL_LAST)
                begin
                    ptr_next   = '0;
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                do_put     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = BLANK_CELL;
                ptr_next  = ptr_reg + 1'b1;
                if (ptr_reg == CELL_LAST)
                begin
                    ptr_next   = '0;
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                emit       = 1'b1;
                emit_data  = rdata_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_put)
        begin
            emit = 1'b1;
            if (put_cmd.kind == K_NEWLINE)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                mem_we    = 1'b1;
                mem_waddr = cursor_idx;
                mem_wdata = put_cmd.word;
                if (col_reg == COL_LAST)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end

        if (emit)
        begin
            row_wide       = ROW_FW'(row_next);
            out_valid_next = 1'b1;
            out_col_next   = COL_FW'(col_next);
            out_row_next   = row_wide[OUT_ROW_W-1:0];
            out_data_next  = emit_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            ptr_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

endmodule

/* rtl/core/text_console_put_scroll_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console with lazy scroll
// Items enter on the s_axis channel: tuser carries the operation, tdata the
// operands. Each item yields one transfer on m_axis with the cursor position
// after the operation and, for a cell read, the cell word.
// The execution engine does a put or set straight from its idle state and a
// read through a read state that waits on the registered read of the screen
// memory; it takes a new item only when idle and its result register is free.
// A put with a scroll pending moves every cell up one row, one read and one
// write per cell, and zeroes the last row before the put. A clear writes every
// cell once.
// After reset the screen is blanked, one cell per cycle; s_axis_tready stays
// low until that pass is over.
// A stalled m_axis holds its result; up to three items wait in the front
// register and queue before s_axis_tready drops.
// ----------------------------------------------------------------------------
module text_console_put_scroll_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // char_code[7:0], attribute[23:8], new_column[30:24], new_row[35:31],
    // cell_address[46:36], zero pad[47]
    input  logic [cps_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // column[6:0], row[11:7], cell_data[27:12], zero pad[31:28]
    output logic [cps_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
    import cps_pkg::*;

    logic                 init_done;
    logic                 f_valid;
    logic                 f_ready;
    cmd_t                 f_cmd;
    logic                 q_valid;
    logic                 q_pop;
    cmd_t                 q_cmd;
    logic [COL_FW-1:0]    out_column;
    logic [OUT_ROW_W-1:0] out_row;
    logic [CELL_W-1:0]    out_data;

    cps_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .enable       (init_done),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .operation    (s_axis_tuser),
        .char_code    (s_axis_tdata[7:0]),
        .attribute    (s_axis_tdata[23:8]),
        .new_column   (s_axis_tdata[30:24]),
        .new_row      (s_axis_tdata[35:31]),
        .cell_address (s_axis_tdata[46:36]),
        .cmd_valid    (f_valid),
        .cmd_ready    (f_ready),
        .cmd          (f_cmd)
    );

    cps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_cmd   (f_cmd),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_cmd   (q_cmd)
    );

    cps_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .init_done  (init_done),
        .cmd_valid  (q_valid),
        .cmd_pop    (q_pop),
        .cmd        (q_cmd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_column (out_column),
        .out_row    (out_row),
        .out_data   (out_data)
    );

    assign m_axis_tdata = {4'b0000, out_data, out_row, out_column};

endmodule

/* rtl/core/cps_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console port checker
// Watches the stream ports for spurious results, cursor column range and output stability.
// ----------------------------------------------------------------------------
`include "text_console_put_scroll_top_assert.svh"

module cps_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [cps_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import cps_pkg::*;

    logic [3:0] pend_reg;
    logic [3:0] pend_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pend_next = pend_reg + 4'(in_xfer) - 4'(out_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `TCPS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `TCPS_ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
    `TCPS_ASSERT_NOW(a_no_spurious, clk, rst_n, m_axis_tvalid, pend_reg != 4'd0, "result without an outstanding item")
    `TCPS_ASSERT_NOW(a_col_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[6:0] <= COL_FW'(COLUMNS - 1), "cursor column out of range")

endmodule

bind text_console_put_scroll_top cps_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_cps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
